/* rtl/snlp_pkg.sv */
// Shared types and constants of the separated number list parser.
// Holds field widths, the queue entry between front and back, and the
// powers-of-ten table. No dependencies.
package snlp_pkg;

  // Payload widths
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 8;
  localparam int WHOLE_W   = 38;
  localparam int FRAC_W    = 37;
  localparam int FLEN_W    = 4;
  localparam int CFG_IDX_W = 2;

  // Digit counters of the front end fit in this width for digit limits up to 31
  localparam int CNT_W = 5;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Results that one input byte leaves in the queue: a number, a status or both
  typedef struct packed {
    logic                  has_num;
    logic                  has_stat;
    logic                  stat_ok;
    logic                  neg;
    logic                  dec;
    logic [INDEX_W-1:0]    index;
    logic [WHOLE_W-1:0]    whole;
    logic [FRAC_W-1:0]     frac;
    logic [CNT_W-1:0]      fcnt;
  } snlp_entry_t;

  // Write side of the queue
  typedef struct packed {
    logic        valid;
    snlp_entry_t entry;
  } snlp_push_t;

  // Fill status of the queue
  typedef struct packed {
    logic empty;
    logic full;
  } snlp_qstat_t;

  // 10^n, truncated to the fraction width
  function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [63:0] p;
    unique case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      default: p = 64'd10000000000000000000;
    endcase
    return p[FRAC_W-1:0];
  endfunction

endpackage

/* rtl/snlp_if.sv */
// Channel interfaces of the separated number list parser: text input,
// result output and register writes. Depends on snlp_pkg.
interface snlp_in_if;
  logic                       valid;
  logic                       ready;
  logic [snlp_pkg::BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface snlp_out_if;
  logic                               valid;
  logic                               ready;
  logic [snlp_pkg::KIND_W-1:0]         result_kind;
  logic [snlp_pkg::INDEX_W-1:0]        number_index;
  logic signed [snlp_pkg::WHOLE_W-1:0] whole_part;
  logic [snlp_pkg::FRAC_W-1:0]         fraction_digits;
  logic [snlp_pkg::FLEN_W-1:0]         fraction_length;
  logic                               final_mark;

  modport source (output valid, output result_kind, output number_index,
                  output whole_part, output fraction_digits,
                  output fraction_length, output final_mark, input ready);
  modport sink (input valid, input result_kind, input number_index,
                input whole_part, input fraction_digits,
                input fraction_length, input final_mark, output ready);
endinterface

interface snlp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [snlp_pkg::CFG_IDX_W-1:0] reg_index;
  logic [snlp_pkg::BYTE_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/snlp_front.sv */
// Front end: takes text bytes, holds the configuration registers and the
// number being read, and queues numbers and status results for the back end.
// Depends on snlp_pkg and snlp_if.
module snlp_front #(
  parameter int MAX_DIGITS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  snlp_in_if.sink               in_ch,
  snlp_cfg_if.sink              cfg_ch,
  input  snlp_pkg::snlp_qstat_t qstat,
  output snlp_pkg::snlp_push_t  push
);

  localparam int RUN_W = $clog2(MAX_DIGITS + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_DIGITS);

  // Register indexes
  localparam logic [snlp_pkg::CFG_IDX_W-1:0] REG_SEPARATOR = 2'd0;
  localparam logic [snlp_pkg::CFG_IDX_W-1:0] REG_EXPECTED  = 2'd1;
  localparam logic [snlp_pkg::CFG_IDX_W-1:0] REG_DECIMAL   = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Sign tracking: none yet, plus, minus just read, minus with more after it
  localparam logic [1:0] SIGN_NONE      = 2'd0;
  localparam logic [1:0] SIGN_PLUS      = 2'd1;
  localparam logic [1:0] SIGN_MINUS_NEW = 2'd2;
  localparam logic [1:0] SIGN_MINUS     = 2'd3;

  localparam logic [7:0] SEP_RESET = 8'd44;

  // Configuration
  logic [7:0] sep_r, sep_nxt;
  logic [7:0] exp_r, exp_nxt;
  logic       dec_r, dec_nxt;

  // Text and number state
  logic [snlp_pkg::WHOLE_W-1:0] whole_r, whole_nxt;
  logic [snlp_pkg::FRAC_W-1:0]  frac_r, frac_nxt;
  logic [RUN_W-1:0]             fcnt_r, fcnt_nxt;
  logic [RUN_W-1:0]             run_r, run_nxt;
  logic [1:0]                   sign_r, sign_nxt;
  logic                         dseen_r, dseen_nxt;
  logic                         pseen_r, pseen_nxt;
  logic [7:0]                   done_r, done_nxt;
  logic                         started_r, started_nxt;
  logic                         disc_r, disc_nxt;

  logic                         accept;
  logic [7:0]                   c;
  logic                         is_digit;
  logic [3:0]                   digit;
  logic [snlp_pkg::WHOLE_W-1:0] whole_mul;
  logic [snlp_pkg::FRAC_W-1:0]  frac_mul;
  logic [1:0]                   sign_eff;
  logic                         bad;
  logic                         clr_num;
  logic                         clr_text;

  assign in_ch.ready  = !qstat.full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && !qstat.full;
  assign c            = in_ch.text_byte;

  // Digit decode and multiply-by-ten accumulate
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit     = 4'(c - CH_ZERO);
  assign whole_mul = (whole_r << 3) + (whole_r << 1) + snlp_pkg::WHOLE_W'(digit);
  assign frac_mul  = (frac_r << 3) + (frac_r << 1) + snlp_pkg::FRAC_W'(digit);

  // Register writes
  always_comb begin
    sep_nxt = sep_r;
    exp_nxt = exp_r;
    dec_nxt = dec_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_SEPARATOR: sep_nxt = cfg_ch.wdata;
        REG_EXPECTED:  exp_nxt = cfg_ch.wdata;
        REG_DECIMAL:   dec_nxt = cfg_ch.wdata[0];
        default: ;
      endcase
    end
  end

  // Sign after a byte that is not a leading minus
  always_comb begin
    sign_eff = sign_r;
    if (sign_r == SIGN_NONE) begin
      sign_eff = SIGN_PLUS;
    end else if (sign_r == SIGN_MINUS_NEW) begin
      sign_eff = SIGN_MINUS;
    end
  end

  // Byte classification and text state update
  always_comb begin
    whole_nxt   = whole_r;
    frac_nxt    = frac_r;
    fcnt_nxt    = fcnt_r;
    run_nxt     = run_r;
    sign_nxt    = sign_r;
    dseen_nxt   = dseen_r;
    pseen_nxt   = pseen_r;
    done_nxt    = done_r;
    started_nxt = started_r;
    disc_nxt    = disc_r;
    bad         = 1'b0;
    clr_num     = 1'b0;
    clr_text    = 1'b0;

    push.valid          = 1'b0;
    push.entry.has_num  = 1'b0;
    push.entry.has_stat = 1'b0;
    push.entry.stat_ok  = 1'b0;
    push.entry.neg      = sign_r[1];
    push.entry.dec      = dec_r;
    push.entry.index    = done_r;
    push.entry.whole    = whole_r;
    push.entry.frac     = frac_r;
    push.entry.fcnt     = snlp_pkg::CNT_W'(fcnt_r);

    if (accept) begin
      priority if (disc_r) begin
        // dropping bytes up to the terminator
        clr_text = (c == CH_NUL);
      end else if (exp_r != 8'd0 && done_r >= exp_r) begin
        // count already reached or passed
        push.valid          = 1'b1;
        push.entry.has_stat = 1'b1;
        push.entry.stat_ok  = (done_r == exp_r);
        if (c == CH_NUL) begin
          clr_text = 1'b1;
        end else begin
          disc_nxt = 1'b1;
        end
      end else if (c == CH_NUL) begin
        // terminator: pending number, then final status
        push.valid          = 1'b1;
        push.entry.has_stat = 1'b1;
        clr_text            = 1'b1;
        priority if (!started_r) begin
          push.entry.stat_ok = (exp_r == 8'd0);
        end else if (sign_r == SIGN_MINUS_NEW) begin
          push.entry.stat_ok = 1'b0;
        end else begin
          push.entry.has_num = 1'b1;
          push.entry.stat_ok = (exp_r == 8'd0) || (done_r + 8'd1 == exp_r);
        end
      end else begin
        started_nxt = 1'b1;
        if (sign_r == SIGN_NONE && c == CH_MINUS) begin
          sign_nxt = SIGN_MINUS_NEW;
        end else begin
          sign_nxt = sign_eff;
          priority if (is_digit && run_r < RUN_MAX) begin
            if (!dec_r) begin
              whole_nxt = {{(snlp_pkg::WHOLE_W - 32){1'b0}}, whole_mul[31:0]};
            end else if (pseen_r) begin
              frac_nxt = frac_mul;
              fcnt_nxt = fcnt_r + 1'b1;
            end else begin
              whole_nxt = whole_mul;
            end
            run_nxt   = run_r + 1'b1;
            dseen_nxt = 1'b1;
          end else if (is_digit) begin
            bad = 1'b1;
          end else if (dec_r && c == CH_POINT && !pseen_r && dseen_r) begin
            run_nxt   = '0;
            dseen_nxt = 1'b0;
            pseen_nxt = 1'b1;
          end else if (c == sep_r && (!dec_r || dseen_r)) begin
            // separator closes the number
            push.valid         = 1'b1;
            push.entry.has_num = 1'b1;
            push.entry.neg     = sign_eff[1];
            done_nxt           = done_r + 8'd1;
            clr_num            = 1'b1;
            if (exp_r != 8'd0 && done_r + 8'd1 == exp_r) begin
              push.entry.has_stat = 1'b1;
              push.entry.stat_ok  = 1'b1;
              disc_nxt            = 1'b1;
            end
          end else begin
            bad = 1'b1;
          end
        end
      end

      // malformed byte: error status, then drop to the terminator
      if (bad) begin
        push.valid          = 1'b1;
        push.entry.has_stat = 1'b1;
        push.entry.stat_ok  = 1'b0;
        disc_nxt            = 1'b1;
      end
    end

    if (clr_num || clr_text) begin
      whole_nxt = '0;
      frac_nxt  = '0;
      fcnt_nxt  = '0;
      run_nxt   = '0;
      sign_nxt  = SIGN_NONE;
      dseen_nxt = 1'b0;
      pseen_nxt = 1'b0;
    end
    if (clr_text) begin
      done_nxt    = '0;
      started_nxt = 1'b0;
      disc_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r     <= SEP_RESET;
      exp_r     <= '0;
      dec_r     <= 1'b0;
      whole_r   <= '0;
      frac_r    <= '0;
      fcnt_r    <= '0;
      run_r     <= '0;
      sign_r    <= SIGN_NONE;
      dseen_r   <= 1'b0;
      pseen_r   <= 1'b0;
      done_r    <= '0;
      started_r <= 1'b0;
      disc_r    <= 1'b0;
    end else begin
      sep_r     <= sep_nxt;
      exp_r     <= exp_nxt;
      dec_r     <= dec_nxt;
      whole_r   <= whole_nxt;
      frac_r    <= frac_nxt;
      fcnt_r    <= fcnt_nxt;
      run_r     <= run_nxt;
      sign_r    <= sign_nxt;
      dseen_r   <= dseen_nxt;
      pseen_r   <= pseen_nxt;
      done_r    <= done_nxt;
      started_r <= started_nxt;
      disc_r    <= disc_nxt;
    end
  end

endmodule

/* rtl/snlp_queue.sv */
// Short queue of result entries between the front and back ends.
// One entry written per cycle while not full, one read while not empty. Depends on snlp_pkg.
module snlp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  snlp_pkg::snlp_push_t  push,
  input  logic                  pop,
  output snlp_pkg::snlp_entry_t head,
  output snlp_pkg::snlp_qstat_t qstat
);

  localparam int PTR_W = $clog2(snlp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(snlp_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(snlp_pkg::QUEUE_DEPTH);

  snlp_pkg::snlp_entry_t slots_r [snlp_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == DEPTH);
  assign head        = slots_r[rd_r];

  assign do_push = push.valid && !qstat.full;
  assign do_pop  = pop && !qstat.empty;

  // Pointer and fill count update
  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_r] <= push.entry;
    end
  end

endmodule

/* rtl/snlp_back.sv */
// Back end: takes queue entries, forms signed numbers and status results,
// and holds them in the output register. Depends on snlp_pkg and snlp_if.
module snlp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  snlp_pkg::snlp_entry_t head,
  input  snlp_pkg::snlp_qstat_t qstat,
  output logic                  pop,
  snlp_out_if.source            out_ch
);

  // Result kinds
  localparam logic [snlp_pkg::KIND_W-1:0] KIND_NUM = 2'd0;
  localparam logic [snlp_pkg::KIND_W-1:0] KIND_OK  = 2'd1;
  localparam logic [snlp_pkg::KIND_W-1:0] KIND_ERR = 2'd2;

  logic                          out_valid_r, out_valid_nxt;
  logic                          num_sent_r, num_sent_nxt;
  logic [snlp_pkg::KIND_W-1:0]   kind_r;
  logic [snlp_pkg::INDEX_W-1:0]  index_r;
  logic [snlp_pkg::WHOLE_W-1:0]  whole_r;
  logic [snlp_pkg::FRAC_W-1:0]   frac_r;
  logic [snlp_pkg::FLEN_W-1:0]   flen_r;
  logic                          fin_r;

  logic                          out_free;
  logic                          take;
  logic                          send_num;
  logic [31:0]                   int_val;
  logic                          frac_zero;
  logic [snlp_pkg::WHOLE_W-1:0]  num_whole;
  logic [snlp_pkg::FRAC_W-1:0]   num_frac;
  logic [snlp_pkg::FLEN_W-1:0]   num_flen;

  assign out_free = !out_valid_r || out_ch.ready;
  assign take     = out_free && !qstat.empty;
  assign send_num = head.has_num && !num_sent_r;
  assign pop      = take && (!send_num || !head.has_stat);

  // Number formatting: 32-bit wrap in integer mode, floor form for negative decimals
  always_comb begin
    int_val   = head.neg ? 32'd0 - head.whole[31:0] : head.whole[31:0];
    frac_zero = (head.frac == '0);
    if (!head.dec) begin
      num_whole = {{(snlp_pkg::WHOLE_W - 32){int_val[31]}}, int_val};
      num_frac  = '0;
      num_flen  = '0;
    end else begin
      num_flen = head.fcnt[snlp_pkg::FLEN_W-1:0];
      if (!head.neg) begin
        num_whole = head.whole;
        num_frac  = head.frac;
      end else if (frac_zero) begin
        num_whole = '0 - head.whole;
        num_frac  = head.frac;
      end else begin
        num_whole = ~head.whole;
        num_frac  = snlp_pkg::pow10(head.fcnt) - head.frac;
      end
    end
  end

  // Sequencing of the number and status parts of an entry
  always_comb begin
    out_valid_nxt = out_valid_r;
    num_sent_nxt  = num_sent_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      num_sent_nxt  = send_num && head.has_stat;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      num_sent_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      num_sent_r  <= num_sent_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (take) begin
      if (send_num) begin
        kind_r  <= KIND_NUM;
        index_r <= head.index;
        whole_r <= num_whole;
        frac_r  <= num_frac;
        flen_r  <= num_flen;
        fin_r   <= 1'b0;
      end else begin
        kind_r  <= head.stat_ok ? KIND_OK : KIND_ERR;
        index_r <= head.index + {{(snlp_pkg::INDEX_W - 1){1'b0}}, head.has_num};
        whole_r <= '0;
        frac_r  <= '0;
        flen_r  <= '0;
        fin_r   <= 1'b1;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_kind     = kind_r;
  assign out_ch.number_index    = index_r;
  assign out_ch.whole_part      = whole_r;
  assign out_ch.fraction_digits = frac_r;
  assign out_ch.fraction_length = flen_r;
  assign out_ch.final_mark      = fin_r;

endmodule

/* rtl/separated_number_list_parser_unit.sv */
// Top level of the separated number list parser: front end, result queue
// and back end. Depends on snlp_pkg, snlp_if, snlp_front, snlp_queue, snlp_back.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   text_byte
//   out_ch   out  valid/ready   result_kind, number_index, whole_part,
//                               fraction_digits, fraction_length, final_mark
//   cfg_ch   in   valid/ready   reg_index, wdata (ready always high)
//
// One text byte is taken per cycle while the queue is not full; a number or status
// is written to the queue when its byte is taken and is valid on out_ch once the
// output register, loaded whenever it is free, takes it from the queue head.
// A byte that gives two results (a number that reaches the count, or a pending
// number at the terminator) keeps its entry at the queue head until both are sent;
// the four-entry queue absorbs this.
// in_ch.ready drops only when the queue is full: out_ch stalls, or bytes that
// give two results arrive faster than the back end drains them.
// Reset (rst_n low, synchronous) restores the default registers and empties
// all state; no clearing pass is needed.
module separated_number_list_parser_unit #(
  parameter int MAX_DIGITS = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  snlp_in_if.sink    in_ch,
  snlp_out_if.source out_ch,
  snlp_cfg_if.sink   cfg_ch
);

  snlp_pkg::snlp_push_t  push;
  snlp_pkg::snlp_entry_t head;
  snlp_pkg::snlp_qstat_t qstat;
  logic                  pop;

  snlp_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .qstat  (qstat),
    .push   (push)
  );

  snlp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  snlp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* dv/tb.sv */
// Testbench of the separated number list parser: directed texts, then random texts
// under changing register settings. Results are checked against an in-bench parse model.
// Depends on snlp_pkg, snlp_if and separated_number_list_parser_unit.
module tb;

  localparam int MAX_DIGITS    = 11;
  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int RANDOM_ITEMS  = 650;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;
  localparam int RUN_LIMIT     = 4_000_000;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_OK     = 2'd1,
    KIND_ERROR  = 2'd2
  } result_kind_e;

  typedef enum logic [snlp_pkg::CFG_IDX_W-1:0] {
    REG_SEPARATOR = 2'd0,
    REG_COUNT     = 2'd1,
    REG_DECIMAL   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_PLUS,
    SIGN_MINUS_FIRST,
    SIGN_MINUS
  } sign_e;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_ALTERNATE
  } rx_mode_e;

  typedef struct packed {
    logic [snlp_pkg::KIND_W-1:0]  kind;
    logic [snlp_pkg::INDEX_W-1:0] idx;
    logic [snlp_pkg::WHOLE_W-1:0] whole;
    logic [snlp_pkg::FRAC_W-1:0]  frac;
    logic [snlp_pkg::FLEN_W-1:0]  flen;
    logic                         fin;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  snlp_in_if  in_ch ();
  snlp_out_if out_ch ();
  snlp_cfg_if cfg_ch ();

  separated_number_list_parser_unit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Parse model: registers and text state
  logic [7:0]  sep_char;
  logic [7:0]  want_count;
  logic        dec_mode;
  logic [63:0] whole_acc;
  logic [63:0] frac_acc;
  int unsigned frac_cnt;
  int unsigned run_len;
  sign_e       sign_st;
  logic        digit_seen;
  logic        point_seen;
  logic [7:0]  nums_done;
  logic        started;
  logic        discarding;

  parse_result_t due_results[$];
  logic [7:0]    text_bytes[$];

  int bytes_queued = 0;
  int bytes_in = 0;
  int n_bad = 0;
  int n_numbers = 0;
  int n_ok = 0;
  int n_err = 0;
  int n_cfg = 0;
  int n_settings = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  bit hold_off = 0;
  bit in_taken = 0;

  function void clear_number();
    whole_acc  = '0;
    frac_acc   = '0;
    frac_cnt   = 0;
    run_len    = 0;
    sign_st    = SIGN_NONE;
    digit_seen = 1'b0;
    point_seen = 1'b0;
  endfunction

  function void clear_text();
    clear_number();
    nums_done  = '0;
    started    = 1'b0;
    discarding = 1'b0;
  endfunction

  function void push_status(input logic ok);
    parse_result_t r;
    r      = '0;
    r.kind = ok ? KIND_OK : KIND_ERROR;
    r.idx  = nums_done;
    r.fin  = 1'b1;
    due_results.push_back(r);
  endfunction

  // Close the pending number; decimal negatives use floor for the whole part
  function void emit_number();
    parse_result_t r;
    logic [63:0]   w;
    logic [63:0]   f;
    logic [63:0]   p;
    logic [31:0]   w32;
    logic          neg;
    r   = '0;
    neg = (sign_st == SIGN_MINUS_FIRST) || (sign_st == SIGN_MINUS);
    if (!dec_mode) begin
      w32 = whole_acc[31:0];
      if (neg) w32 = -w32;
      r.whole = {{(snlp_pkg::WHOLE_W-32){w32[31]}}, w32};
    end else begin
      p = 64'd1;
      repeat (frac_cnt) p = p * 10;
      w = whole_acc;
      f = frac_acc;
      if (neg) begin
        if (f == 0) begin
          w = -w;
        end else begin
          w = -(w + 1);
          f = p - f;
        end
      end
      r.whole = w[snlp_pkg::WHOLE_W-1:0];
      r.frac  = f[snlp_pkg::FRAC_W-1:0];
      r.flen  = frac_cnt[snlp_pkg::FLEN_W-1:0];
    end
    r.kind = KIND_NUMBER;
    r.idx  = nums_done;
    due_results.push_back(r);
    nums_done++;
    clear_number();
  endfunction

  // One accepted text byte: update the model and queue the results it causes
  function void parse_byte(input logic [7:0] c);
    logic is_digit;
    if (discarding) begin
      if (c == CH_NUL) clear_text();
      return;
    end
    // count already passed, e.g. after a register write mid-text
    if (want_count != 0 && nums_done >= want_count) begin
      push_status(nums_done == want_count);
      if (c == CH_NUL) clear_text();
      else discarding = 1'b1;
      return;
    end
    if (c == CH_NUL) begin
      if (!started) begin
        push_status(want_count == 0);
      end else if (sign_st == SIGN_MINUS_FIRST) begin
        push_status(1'b0);
      end else begin
        emit_number();
        push_status(want_count == 0 || nums_done == want_count);
      end
      clear_text();
      return;
    end
    started = 1'b1;
    if (sign_st == SIGN_NONE) begin
      if (c == CH_MINUS) begin
        sign_st = SIGN_MINUS_FIRST;
        return;
      end
      sign_st = SIGN_PLUS;
    end else if (sign_st == SIGN_MINUS_FIRST) begin
      sign_st = SIGN_MINUS;
    end
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (is_digit && run_len < MAX_DIGITS) begin
      if (!dec_mode) begin
        whole_acc = (whole_acc * 10 + (c - CH_ZERO)) & 64'hFFFF_FFFF;
      end else if (point_seen) begin
        frac_acc = frac_acc * 10 + (c - CH_ZERO);
        frac_cnt++;
      end else begin
        whole_acc = whole_acc * 10 + (c - CH_ZERO);
      end
      run_len++;
      digit_seen = 1'b1;
      return;
    end
    if (!is_digit && dec_mode && c == CH_POINT && !point_seen && digit_seen) begin
      run_len    = 0;
      digit_seen = 1'b0;
      point_seen = 1'b1;
      return;
    end
    if (!is_digit && c == sep_char && (!dec_mode || digit_seen)) begin
      emit_number();
      if (want_count != 0 && nums_done == want_count) begin
        push_status(1'b1);
        discarding = 1'b1;
      end
      return;
    end
    // bad byte or too many digits
    push_status(1'b0);
    discarding = 1'b1;
  endfunction

  function void check_result(input parse_result_t got);
    parse_result_t want;
    case (got.kind)
      KIND_NUMBER: n_numbers++;
      KIND_OK:     n_ok++;
      default:     n_err++;
    endcase
    if (due_results.size() == 0) begin
      n_bad++;
      if (n_bad <= MAX_REPORTS)
        $display("unexpected result: kind %0d index %0d whole %0d", got.kind, got.idx,
                 $signed(got.whole));
      return;
    end
    want = due_results.pop_front();
    if (got !== want) begin
      n_bad++;
      if (n_bad <= MAX_REPORTS) begin
        $display("mismatch (expected/actual): kind %0d/%0d index %0d/%0d final %0d/%0d",
                 want.kind, got.kind, want.idx, got.idx, want.fin, got.fin);
        $display("  whole %0d/%0d frac %0d/%0d frac_len %0d/%0d",
                 $signed(want.whole), $signed(got.whole), want.frac, got.frac,
                 want.flen, got.flen);
      end
    end
  endfunction

  // Sample both channels at the rising edge
  always @(posedge clk) begin : mon
    parse_result_t got;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind  = out_ch.result_kind;
      got.idx   = out_ch.number_index;
      got.whole = out_ch.whole_part;
      got.frac  = out_ch.fraction_digits;
      got.flen  = out_ch.fraction_length;
      got.fin   = out_ch.final_mark;
      check_result(got);
    end
    if (in_taken) begin
      bytes_in++;
      parse_byte(in_ch.text_byte);
    end
  end

  // Text sender: bursts of random length, random gaps; an item holds until taken
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.text_byte <= '0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (text_bytes.size() > 0) begin
        in_ch.valid     <= 1'b1;
        in_ch.text_byte <= text_bytes.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern switches between modes
  rx_mode_e rx_mode = RX_ALWAYS;
  int       rx_left = 0;
  bit       rx_toggle = 0;

  always @(negedge clk) begin
    rx_toggle = !rx_toggle;
    if (hold_off || !rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(10, 60);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_ALWAYS:   out_ch.ready <= 1'b1;
        RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     out_ch.ready <= rx_toggle;
      endcase
    end
  end

  // Long receiver hold-off so the queue fills and the input stalls
  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs > holds_done) begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
        holds_done++;
      end
    end
  end

  initial begin
    #RUN_LIMIT;
    $display("timeout: %0d text bytes accepted, %0d results still due", bytes_in,
             due_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    text_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic put_text(input string s, input bit terminate);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    if (terminate) push_byte(CH_NUL);
  endtask

  // Wait until all bytes are taken and all results have come, then let the block settle
  task automatic wait_idle();
    while (text_bytes.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SEPARATOR: sep_char = val;
      REG_COUNT:     want_count = val;
      default:       dec_mode = val[0];
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] sep, input logic [7:0] cnt, input logic dec);
    write_reg(REG_SEPARATOR, sep);
    write_reg(REG_COUNT, cnt);
    // upper bits of the mode write are don't-care
    write_reg(REG_DECIMAL, 8'(($urandom_range(0, 255) & 8'hFE) | dec));
    n_settings++;
  endtask

  // Digit run: mostly short, sometimes empty, at the limit or one past it
  task automatic put_digits();
    int  pick;
    int  n_dig;
    bit  nines;
    pick  = $urandom_range(0, 19);
    nines = (pick == 1) && $urandom_range(0, 1);
    if (pick == 0) n_dig = 0;
    else if (pick == 1) n_dig = MAX_DIGITS;
    else if (pick == 2) n_dig = MAX_DIGITS + 1;
    else n_dig = $urandom_range(1, 6);
    repeat (n_dig) push_byte(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Mostly well-formed lists with random content, some noise
  task automatic put_random_text(input bit terminate);
    int n_nums;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(1, 255)));
    end else begin
      n_nums = $urandom_range(0, 5);
      for (int k = 0; k < n_nums; k++) begin
        if ($urandom_range(0, 3) == 0) push_byte(CH_MINUS);
        put_digits();
        if (dec_mode && $urandom_range(0, 2) == 0) begin
          push_byte(CH_POINT);
          put_digits();
        end
        if ($urandom_range(0, 24) == 0) push_byte(8'($urandom_range(1, 255)));
        if (k < n_nums - 1 || $urandom_range(0, 4) == 0) push_byte(sep_char);
      end
    end
    if (terminate) push_byte(CH_NUL);
  endtask

  // Stimulus
  initial begin
    int          ph;
    int          r;
    int          target;
    int          drain;
    logic [7:0]  sep;
    logic [7:0]  cnt;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wdata     = '0;
    sep_char   = CH_COMMA;
    want_count = '0;
    dec_mode   = 1'b0;
    clear_text();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Defaults: sign, empty fields, trailing separator, lone minus, empty text, bad byte, digit limit
    put_text("-12,,", 1);
    put_text("-", 1);
    put_text("", 1);
    push_byte(8'hFF);
    push_byte(CH_NUL);
    put_text("99999999999", 1);
    put_text("123456789012", 1);

    // Count reached mid-text, then not met
    wait_idle();
    write_reg(REG_COUNT, 8'd2);
    put_text("5,6,7", 1);
    put_text("1", 1);

    // Count passed by a register write mid-text: error, then equal
    wait_idle();
    write_reg(REG_COUNT, 8'd0);
    put_text("1,2,", 0);
    wait_idle();
    write_reg(REG_COUNT, 8'd1);
    push_byte(CH_NUL);
    wait_idle();
    write_reg(REG_COUNT, 8'd0);
    put_text("3,", 0);
    wait_idle();
    write_reg(REG_COUNT, 8'd1);
    push_byte(CH_NUL);

    // Decimal format: floor of negatives, point at the end, second point, bare point, full digit runs
    wait_idle();
    set_regs(CH_SEMI, 8'd0, 1'b1);
    put_text("-0.25;9.", 1);
    put_text("1.2.3", 1);
    put_text(".5", 1);
    put_text("-99999999999.99999999999", 1);

    // Separator equal to the minus sign, then to a digit
    wait_idle();
    set_regs(CH_MINUS, 8'd0, 1'b0);
    put_text("--5-3", 1);
    wait_idle();
    write_reg(REG_SEPARATOR, CH_ZERO + 8'd5);
    put_text("151", 1);

    // Random phases, each under its own register setting
    target = bytes_queued + RANDOM_ITEMS;
    ph = 0;
    while (bytes_queued < target) begin
      wait_idle();
      if (ph == 0) begin
        set_regs(8'd255, 8'd255, 1'b1);
      end else if (ph == 1) begin
        set_regs(8'd1, 8'd0, 1'b0);
      end else if (ph == 2 || ph == 5) begin
        set_regs(CH_COMMA, 8'd0, 1'($urandom_range(0, 1)));
        hold_reqs++;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5) sep = CH_COMMA;
        else if (r == 5) sep = CH_SEMI;
        else if (r == 6) sep = CH_MINUS;
        else if (r == 7) sep = CH_POINT;
        else if (r == 8) sep = CH_ZERO + 8'($urandom_range(0, 9));
        else sep = 8'($urandom_range(1, 255));
        r = $urandom_range(0, 9);
        if (r < 5) cnt = 8'd0;
        else if (r < 9) cnt = 8'($urandom_range(1, 4));
        else cnt = 8'($urandom_range(5, 255));
        set_regs(sep, cnt, 1'($urandom_range(0, 1)));
      end
      r = bytes_queued + ((ph == 2 || ph == 5) ? 120 : $urandom_range(50, 110));
      while (bytes_queued < r) put_random_text(1'b1);
      // sometimes leave a text open across the next register writes
      if ($urandom_range(0, 2) == 0) put_random_text(1'b0);
      ph++;
    end
    put_random_text(1'b1);
    push_byte(CH_NUL);

    while (text_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    drain = 0;
    while (due_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0d results never arrived", due_results.size());
      n_bad += due_results.size();
    end

    $display("Sent %0d text bytes under %0d register settings (%0d register writes).",
             bytes_in, n_settings, n_cfg);
    $display("Checked %0d numbers, %0d ok and %0d error statuses; %0d mismatches.",
             n_numbers, n_ok, n_err, n_bad);
    if (n_bad == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
